/* sv/bra_pkg.sv */
// Shared types and constants for the bitmap run allocator.
// Used by bra_map_mem, bra_run_unit, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

  localparam int MAP_BYTES = 64;
  localparam int MAP_BITS  = MAP_BYTES * 8;
  localparam int MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int MAP_CW    = $clog2(MAP_BYTES + 1);

  localparam int CFG_AW = 3;
  localparam logic REG_BYTES_IN_USE = 1'b0;
  localparam logic [6:0] BYTES_IN_USE_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR_ALL = 2'd0,
    OP_TEST      = 2'd1,
    OP_SET       = 2'd2,
    OP_SCAN      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_all;
  } mem_req_t;

endpackage

`default_nettype wire

/* sv/bra_map_mem.sv */
// Bitmap storage: one byte-wide synchronous RAM plus per-byte valid flags.
// Depends on bra_pkg; a byte never written since reset or clear reads as zero.
`timescale 1ns / 1ps
`default_nettype none

module bra_map_mem
  import bra_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mem_req_t   req,
  output logic [7:0]      rd_byte
);

  logic [7:0]           mem [MAP_BYTES];
  logic [7:0]           rd_data_r;
  logic                 rd_vld_r;
  logic [MAP_BYTES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_vld_r  <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr_all) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_byte = rd_vld_r ? rd_data_r : 8'h00;

endmodule

`default_nettype wire

/* sv/bra_run_unit.sv */
// Run tracker for scan: folds one bitmap byte into the current clear-bit run.
// Depends on bra_pkg; purely combinational, eight bit steps per byte.
`timescale 1ns / 1ps
`default_nettype none

module bra_run_unit
  import bra_pkg::*;
(
  input  wire logic [7:0]        map_byte,
  input  wire logic [MAP_AW-1:0] byte_addr,
  input  wire logic [9:0]        run_in,
  input  wire logic [9:0]        run_len,
  output logic [9:0]             run_out,
  output logic                   hit,
  output logic [8:0]             start_index
);

  logic [9:0]  run;
  logic [2:0]  pos;
  logic [15:0] start_full;

  always_comb begin
    run = run_in;
    hit = 1'b0;
    pos = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (!hit) begin
        if (!map_byte[j]) begin
          run = run + 10'd1;
          if (run == run_len && run_len != 10'd0) begin
            hit = 1'b1;
            pos = 3'(j);
          end
        end else begin
          run = 10'd0;
        end
      end
    end
    run_out = run;
    // first bit of the run: last clear bit position + 1 - length
    start_full  = 16'({byte_addr, pos}) + 16'd1 - 16'(run_len);
    start_index = start_full[8:0];
  end

endmodule

`default_nettype wire

/* sv/bitmap_run_allocator.sv */
// Top level of the first-fit bitmap run allocator: control sequencer and APB register.
// Depends on bra_pkg, bra_map_mem and bra_run_unit.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps a 512-bit map (64 bytes, bit i in byte i/8 at position i%8)
// in one RAM with a read and a write port and serves one item at a time. Clear all
// takes effect at once through per-byte valid flags and goes straight to the
// response state; test and set read the byte, then answer or write back. Scan
// streams one map byte per cycle through the run tracker, stopping at the first
// fit or after min(bytes_in_use, 64) bytes; the single RAM read port sets that rate.
// The next item is taken as soon as the result sits in the output register.
// bytes_in_use (APB offset 0) limits scan only; values above 64 act as 64.
module bitmap_run_allocator
  import bra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic [8:0]        in_bit_index,
  input  wire logic              in_set_value,
  input  wire logic [9:0]        in_run_length,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output logic [8:0]             out_start_index,
  output logic                   out_bit_value,

  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [8:0]        idx_r, idx_nxt;
  logic              val_r, val_nxt;
  logic [9:0]        len_r, len_nxt;
  logic [MAP_CW-1:0] nbytes_r, nbytes_nxt;
  logic [MAP_CW-1:0] scan_addr_r, scan_addr_nxt;
  logic              pend_r, pend_nxt;
  logic [MAP_AW-1:0] pend_byte_r, pend_byte_nxt;
  logic [9:0]        run_r, run_nxt;

  logic       res_found_r, res_found_nxt;
  logic [8:0] res_start_r, res_start_nxt;
  logic       res_bit_r, res_bit_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  logic [8:0] out_start_r, out_start_nxt;
  logic       out_bit_r, out_bit_nxt;

  logic [6:0] bytes_in_use_r;

  mem_req_t   mem_req;
  logic [7:0] rd_byte;
  logic [7:0] new_byte;
  logic       idx_in_range;
  logic       in_idx_in_range;
  logic [9:0] tr_run;
  logic       tr_hit;
  logic [8:0] tr_start;
  logic       accept;
  logic       cfg_wr;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == REG_BYTES_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= BYTES_IN_USE_RST;
    end else if (cfg_wr) begin
      bytes_in_use_r <= cfg_pwdata[6:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == REG_BYTES_IN_USE) begin
      cfg_prdata = {25'd0, bytes_in_use_r};
    end
  end

  // ---------------------------------------------------------------- storage
  bra_map_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_byte (rd_byte)
  );

  bra_run_unit u_run (
    .map_byte    (rd_byte),
    .byte_addr   (pend_byte_r),
    .run_in      (run_r),
    .run_len     (len_r),
    .run_out     (tr_run),
    .hit         (tr_hit),
    .start_index (tr_start)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign in_idx_in_range = int'(in_bit_index) < MAP_BITS;
  assign idx_in_range    = int'(idx_r) < MAP_BITS;

  always_comb begin
    new_byte = rd_byte;
    new_byte[idx_r[2:0]] = val_r;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    len_nxt       = len_r;
    nbytes_nxt    = nbytes_r;
    scan_addr_nxt = scan_addr_r;
    pend_nxt      = 1'b0;
    pend_byte_nxt = pend_byte_r;
    run_nxt       = run_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    res_bit_nxt   = res_bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_bit_nxt   = out_bit_r;

    mem_req         = '0;
    mem_req.rd_addr = MAP_AW'(in_bit_index >> 3);
    mem_req.wr_addr = MAP_AW'(idx_r >> 3);
    mem_req.wr_data = new_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt        = op_t'(in_operation);
          idx_nxt       = in_bit_index;
          val_nxt       = in_set_value;
          len_nxt       = in_run_length;
          scan_addr_nxt = '0;
          run_nxt       = 10'd0;
          res_found_nxt = 1'b1;
          res_start_nxt = 9'd0;
          res_bit_nxt   = 1'b0;
          if (int'(bytes_in_use_r) > MAP_BYTES) begin
            nbytes_nxt = MAP_CW'(MAP_BYTES);
          end else begin
            nbytes_nxt = MAP_CW'(bytes_in_use_r);
          end
          unique case (op_t'(in_operation))
            OP_CLEAR_ALL: begin
              mem_req.clr_all = 1'b1;
              state_nxt       = ST_RESP;
            end
            OP_TEST, OP_SET: begin
              mem_req.rd_en = in_idx_in_range;
              state_nxt     = ST_ACCESS;
            end
            OP_SCAN: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        if (op_r == OP_SET) begin
          mem_req.wr_en = idx_in_range;
        end else begin
          res_bit_nxt = idx_in_range && rd_byte[idx_r[2:0]];
        end
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        if (pend_r && tr_hit) begin
          // first fit: stop here, drop any read in flight
          res_found_nxt = 1'b1;
          res_start_nxt = tr_start;
          state_nxt     = ST_RESP;
        end else begin
          if (pend_r) begin
            run_nxt = tr_run;
          end
          if (scan_addr_r < nbytes_r) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = MAP_AW'(scan_addr_r);
            pend_nxt        = 1'b1;
            pend_byte_nxt   = MAP_AW'(scan_addr_r);
            scan_addr_nxt   = scan_addr_r + MAP_CW'(1);
          end else if (!pend_r) begin
            res_found_nxt = 1'b0;
            res_start_nxt = 9'd0;
            state_nxt     = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_bit_nxt   = res_bit_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    len_r       <= len_nxt;
    nbytes_r    <= nbytes_nxt;
    scan_addr_r <= scan_addr_nxt;
    pend_byte_r <= pend_byte_nxt;
    run_r       <= run_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_bit_r   <= res_bit_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_bit_r   <= out_bit_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_start_index = out_start_r;
  assign out_bit_value   = out_bit_r;

endmodule

`default_nettype wire

/* sv/bra_checker.sv */
// Port-level checks for the bitmap run allocator, bound to the top level.
// Depends on bitmap_run_allocator port names only.
`timescale 1ns / 1ps
`default_nettype none

module bra_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_found,
  input wire logic [8:0] out_start_index,
  input wire logic       out_bit_value
);

  // a result beat waits, unchanged, until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_start_index) && $stable(out_bit_value))
    else $error("result beat dropped or changed while stalled");

  a_miss_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_start_index == 9'd0)
    else $error("failed scan reports a nonzero start");

  a_bit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bit_value |-> out_found && out_start_index == 9'd0)
    else $error("test result carries scan fields");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for bitmap_run_allocator: directed and random allocator traffic.
// Depends on bra_pkg and the allocator RTL; keeps its own bitmap and register copy.
`timescale 1ns / 1ps

module testbench;
  import bra_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_IDLE    = 17;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic       found;
    logic [8:0] start_index;
    logic       bit_value;
  } alloc_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_operation;
  logic [8:0]        in_bit_index;
  logic              in_set_value;
  logic [9:0]        in_run_length;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [8:0]        out_start_index;
  logic              out_bit_value;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Shadow of the allocator: bitmap, bytes_in_use, results still owed.
  logic [MAP_BITS-1:0] alloc_map;
  logic [6:0]          bytes_in_use_reg;
  alloc_result_t       pending_results[$];
  alloc_result_t       last_result;
  alloc_result_t       got_beat;
  alloc_result_t       want_beat;

  int  error_count;
  int  cycle_count;
  bit  in_idle_on;
  bit  out_idle_on;

  bitmap_run_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_bit_index    (in_bit_index),
    .in_set_value    (in_set_value),
    .in_run_length   (in_run_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_start_index (out_start_index),
    .out_bit_value   (out_bit_value),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // First-fit allocator behavior; updates the shadow bitmap.
  function automatic alloc_result_t apply_map_op(op_t op, logic [8:0] idx, logic v,
                                                 logic [9:0] len);
    alloc_result_t r;
    int span;
    int run;
    r = '{found: 1'b1, start_index: 9'd0, bit_value: 1'b0};
    case (op)
      OP_CLEAR_ALL: alloc_map = '0;
      OP_TEST: begin
        if (int'(idx) < MAP_BITS) r.bit_value = alloc_map[idx];
      end
      OP_SET: begin
        if (int'(idx) < MAP_BITS) alloc_map[idx] = v;
      end
      default: begin
        span = ((int'(bytes_in_use_reg) > MAP_BYTES) ? MAP_BYTES : int'(bytes_in_use_reg)) * 8;
        r.found = 1'b0;
        run = 0;
        if (len != 0 && int'(len) <= span) begin
          for (int i = 0; i < span && !r.found; i++) begin
            run = alloc_map[i] ? 0 : run + 1;
            if (run == int'(len)) begin
              r.found = 1'b1;
              r.start_index = 9'(i + 1 - run);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Sender: random gap, then hold the beat until accepted.
  task automatic send_op(input op_t op, input int idx, input logic v, input int len);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_bit_index  <= 9'(idx);
    in_set_value  <= v;
    in_run_length <= 10'(len);
    do @(posedge clk); while (!in_ready);
    last_result = apply_map_op(op, 9'(idx), v, 10'(len));
    pending_results.push_back(last_result);
  endtask

  // Drop valid in the acceptance step, then hold until every result is back.
  task automatic wait_drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bytes_in_use(input logic [6:0] v);
    wait_drain();
    repeat (3) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(REG_BYTES_IN_USE));
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    bytes_in_use_reg = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall per beat, stretches without stalls when idling is off.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_beat = {out_found, out_start_index, out_bit_value};
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result found=%0b start=%0d bit=%0b",
                             got_beat.found, got_beat.start_index, got_beat.bit_value));
      end else begin
        want_beat = pending_results.pop_front();
        if (got_beat !== want_beat)
          note_error($sformatf("expected found=%0b start=%0d bit=%0b, got found=%0b start=%0d bit=%0b",
                               want_beat.found, want_beat.start_index, want_beat.bit_value,
                               got_beat.found, got_beat.start_index, got_beat.bit_value));
      end
    end
  end

  task automatic test_reset_state();
    send_op(OP_TEST, 0, 1'b0, 1);
    send_op(OP_TEST, 511, 1'b1, 1);
    send_op(OP_SCAN, 0, 1'b0, 512);
    send_op(OP_SCAN, 0, 1'b0, 513);
    send_op(OP_SCAN, 0, 1'b0, 0);
  endtask

  task automatic test_bit_ops();
    send_op(OP_SET, 0, 1'b1, 0);
    send_op(OP_SET, 511, 1'b1, 0);
    send_op(OP_SET, 256, 1'b1, 0);
    send_op(OP_SET, 256, 1'b0, 1023);
    send_op(OP_TEST, 511, 1'b0, 0);
    send_op(OP_TEST, 256, 1'b1, 0);
    send_op(OP_SCAN, 0, 1'b0, 1);
    send_op(OP_SCAN, 0, 1'b0, 511);
    send_op(OP_SCAN, 0, 1'b0, 510);
  endtask

  task automatic test_clear_all();
    send_op(OP_CLEAR_ALL, 511, 1'b1, 1023);
    send_op(OP_TEST, 511, 1'b0, 0);
    send_op(OP_SCAN, 0, 1'b0, 1023);
  endtask

  task automatic test_bytes_in_use();
    write_bytes_in_use(7'd1);
    send_op(OP_SCAN, 0, 1'b0, 8);
    send_op(OP_SCAN, 0, 1'b0, 9);
    send_op(OP_SET, 300, 1'b1, 0);
    send_op(OP_TEST, 300, 1'b0, 0);
    write_bytes_in_use(7'd0);
    send_op(OP_SCAN, 0, 1'b0, 1);
    write_bytes_in_use(7'd127);
    send_op(OP_SCAN, 0, 1'b0, 512);
    send_op(OP_CLEAR_ALL, 0, 1'b0, 0);
    send_op(OP_SCAN, 0, 1'b0, 512);
    write_bytes_in_use(7'd64);
  endtask

  // Allocate/free traffic: scans followed by marking the run, frees, tests, noise.
  task automatic test_random_alloc(input int n_items);
    logic [6:0] phase_sizes[8] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd8, 7'd65, 7'd33};
    int count;
    int pick;
    int len;
    int base;
    int n;
    count = 0;
    while (count < n_items) begin
      if (count % 60 == 0) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0)
          write_bytes_in_use(7'($urandom_range(1, 64)));
        else
          write_bytes_in_use(phase_sizes[$urandom_range(0, 7)]);
      end
      if ($urandom_range(0, 39) == 0) wait_drain();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
        send_op(OP_SCAN, $urandom_range(0, 511), 1'($urandom), len);
        count++;
        if (last_result.found) begin
          base = last_result.start_index;
          n = (len > 32) ? 32 : len;
          for (int k = 0; k < n && base + k < MAP_BITS; k++) begin
            send_op(OP_SET, base + k, 1'b1, $urandom_range(0, 1023));
            count++;
          end
        end
      end else if (pick < 75) begin
        base = $urandom_range(0, 511);
        n = $urandom_range(1, 8);
        for (int k = 0; k < n && base + k < MAP_BITS; k++) begin
          send_op(OP_SET, base + k, 1'b0, $urandom_range(0, 1023));
          count++;
        end
      end else if (pick < 90) begin
        send_op(OP_TEST, $urandom_range(0, 511), 1'($urandom), $urandom_range(0, 1023));
        count++;
      end else if (pick < 94) begin
        send_op(OP_SET, $urandom_range(0, 511), 1'($urandom), $urandom_range(0, 1023));
        count++;
      end else if (pick < 96) begin
        send_op(OP_CLEAR_ALL, $urandom_range(0, 511), 1'($urandom), $urandom_range(0, 1023));
        count++;
      end else begin
        send_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 511), 1'($urandom),
                $urandom_range(0, 1023));
        count++;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_CLEAR_ALL;
    in_bit_index  <= '0;
    in_set_value  <= 1'b0;
    in_run_length <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    cycle_count   = 0;
    error_count   = 0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    alloc_map        = '0;
    bytes_in_use_reg = BYTES_IN_USE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_bit_ops();
    test_clear_all();
    test_bytes_in_use();
    test_random_alloc(500);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bra_pkg.sv
sv/bra_map_mem.sv
sv/bra_run_unit.sv
sv/bitmap_run_allocator.sv
sv/bra_checker.sv
tb/sv/testbench.sv
